// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also runs through reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int AGE_W      = IDX_W;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        FUNC_GET      = 2'd0,
        FUNC_PUT      = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_CLEAR    = 2'd3
    } t_func;

    typedef struct packed {
        t_func                 func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic [CNT_W-1:0]      occupancy;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, lru replacement
// datapath: request registered in r_in, then result registered in r_out
// throughput: one transaction per cycle while the output is not stalled, lookup and update in one pass
// reset: synchronous active low, empties cache, capacity back to 16
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit import lkvc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_req              i_in,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_rsp                   o_out,
    // capacity register
    input  wire logic              i_cfg_we,
    input  wire logic [CAP_W-1:0]  i_cfg_data
);

    // request register in front of the lookup
    logic             r_in_vld;
    t_req             r_in;

    // result register
    logic             r_out_vld;
    t_rsp             r_out;
    t_rsp             n_out;

    // entry storage: keys and values only meaningful while the valid bit is set
    logic [KEY_BITS-1:0]   r_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [AGE_W-1:0]      r_age   [ENTRIES];
    logic [AGE_W-1:0]      n_age   [ENTRIES];
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      n_used;
    logic [CAP_W-1:0]      r_cap;

    // lookup results
    logic [ENTRIES-1:0] w_match;
    logic               w_found;
    logic [IDX_W-1:0]   w_slot;
    logic [IDX_W-1:0]   w_victim;
    logic [IDX_W-1:0]   w_free;
    logic [AGE_W-1:0]   w_oldest;
    logic [CNT_W-1:0]   w_eff_cap;
    logic               w_full;

    // update controls
    logic               w_adv;
    logic               w_touch;
    logic               w_write_val;
    logic               w_write_key;
    logic [IDX_W-1:0]   w_target;
    logic [CNT_W-1:0]   w_rank;

    // the request register moves on whenever the result register is free or drained
    assign w_adv       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // effective capacity: zero acts as one, anything past the entry count is clipped
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (32'(r_cap) > ENTRIES) begin
            w_eff_cap = CNT_W'(ENTRIES);
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
    end

    assign w_full   = (r_used >= w_eff_cap);
    // rank of the least recent entry; only used while the cache holds something
    assign w_oldest = AGE_W'(r_used - CNT_W'(1));

    // parallel key compare, one comparator per entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == r_in.key);
        end
    end

    assign w_found = |w_match;

    // lowest index wins in all three searches
    always_comb begin
        w_slot   = '0;
        w_victim = '0;
        w_free   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_slot = IDX_W'(i);
            end
            if (r_valid[i] && (r_age[i] == w_oldest)) begin
                w_victim = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free = IDX_W'(i);
            end
        end
    end

    // pick the entry that becomes most recent, and the rank it had before
    //   hit: the matching entry
    //   miss on a full cache: the least recent entry is overwritten
    //   miss with room: a free entry, and every valid entry ages by one
    always_comb begin
        w_touch     = 1'b0;
        w_write_val = 1'b0;
        w_write_key = 1'b0;
        n_used      = r_used;
        if (w_found) begin
            w_target = w_slot;
            w_rank   = CNT_W'(r_age[w_slot]);
        end else if (w_full) begin
            w_target = w_victim;
            w_rank   = CNT_W'(r_age[w_victim]);
        end else begin
            w_target = w_free;
            w_rank   = r_used;
        end

        unique case (r_in.func)
            FUNC_GET: begin
                w_touch = w_found;
            end
            FUNC_PUT: begin
                w_touch     = 1'b1;
                w_write_val = 1'b1;
                w_write_key = !w_found;
                if (!w_found && !w_full) begin
                    n_used = r_used + CNT_W'(1);
                end
            end
            FUNC_CONTAINS: begin
                w_touch = 1'b0;
            end
            FUNC_CLEAR: begin
                n_used = '0;
            end
            default: begin
                w_touch = 1'b0;
            end
        endcase
    end

    // recency update: entries younger than the touched one age by one
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (r_in.func == FUNC_CLEAR) begin
            n_valid = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                n_age[i] = '0;
            end
        end else if (w_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (CNT_W'(r_age[i]) < w_rank)) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            n_age[w_target]   = '0;
            n_valid[w_target] = 1'b1;
        end
    end

    // result word
    always_comb begin
        n_out.hit        = w_found && (r_in.func != FUNC_CLEAR);
        n_out.read_value = (r_in.func == FUNC_GET && w_found) ? r_value[w_slot] : '0;
        n_out.occupancy  = n_used;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
            r_used    <= '0;
            r_cap     <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (!r_in_vld || w_adv) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_adv) begin
                r_valid <= n_valid;
                r_used  <= n_used;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_age[i] <= n_age[i];
                end
            end
        end
    end

    // payload: request, result and entry contents
    always_ff @(posedge i_clk) begin
        if (!r_in_vld || w_adv) begin
            r_in <= i_in;
        end
        if (w_adv) begin
            r_out <= n_out;
            if (w_write_val) begin
                r_value[w_target] <= r_in.value_in;
            end
            if (w_write_key) begin
                r_key[w_target] <= r_in.key;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker
// port level checks for the key-value cache, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lkvc_checker import lkvc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_in_stall,
    input  wire logic             o_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_rsp             o_out
);

    `CHK_ASSERT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    `CHK_ASSERT(a_stall_only_on_blocked_output, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled while output can drain")

    `CHK_ASSERT(a_data_implies_hit, i_clk, i_rst_n, (o_out_valid && (o_out.read_value != '0)) |-> o_out.hit, "read data without a hit")

    `CHK_ASSERT(a_occupancy_bound, i_clk, i_rst_n, o_out_valid |-> (32'(o_out.occupancy) <= ENTRIES), "occupancy above entry count")

    `CHK_ASSERT(a_result_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "stalled result changed")

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
